>>> sv/assert_macros.svh
// Assertion macros used by the bsc_divider module.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define BSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

>>> sv/bsc_pkg.sv
// ============================================================================
// bsc_pkg
// Shared types and constants of the barometric sensor compensation block.
// ============================================================================
package bsc_pkg;

    // Pipeline depths.
    localparam int FRONT_STAGES = 10;
    localparam int DIV_STAGES   = 64;
    localparam int BACK_STAGES  = 7;

    // Field widths.
    localparam int RAW_W   = 20;
    localparam int CENTI_W = 19;
    localparam int PRESS_W = 32;
    localparam int DEN_W   = 31;

    // Fixed-point constants of the compensation formula.
    localparam logic [32:0] FINE_OFFSET = 33'd128000;
    localparam logic [20:0] PRESS_FULL  = 21'd1048576;
    localparam logic [11:0] PRESS_SCALE = 12'd3125;
    localparam logic [63:0] P1_BIAS     = 64'h0000_8000_0000_0000;
    localparam logic [31:0] CENTI_ROUND = 32'd128;
    localparam logic [63:0] DIV256_BIAS = 64'd255;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_TEMP_CAL   = 2'd0,
        REG_PRESS_LO   = 2'd1,
        REG_PRESS_HI   = 2'd2,
        REG_PRESS_LAST = 2'd3
    } bsc_reg_t;

    // Data that rides alongside the division.
    typedef struct packed {
        logic [CENTI_W-1:0] temp_centi;
        logic               fault;
        logic               q_neg;
    } bsc_side_t;

endpackage

>>> sv/bsc_divider.sv
// ============================================================================
// bsc_divider
// Pipelined unsigned 64 by 31 bit restoring divider, one quotient bit per stage.
// ============================================================================
`include "assert_macros.svh"

module bsc_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [63:0]                  numer,
    input  logic [bsc_pkg::DEN_W-1:0]    denom,
    input  bsc_pkg::bsc_side_t           side_in,
    output logic                         out_valid,
    output logic [63:0]                  quot,
    output bsc_pkg::bsc_side_t           side_out
);

    localparam int N = bsc_pkg::DIV_STAGES;
    localparam int W = bsc_pkg::DEN_W;

    logic [N-1:0]       vld_reg;
    logic [W-1:0]       rem_reg  [N];
    logic [63:0]        nq_reg   [N];
    logic [W-1:0]       den_reg  [N];
    bsc_pkg::bsc_side_t side_reg [N];

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    // One restoring step per stage: shift in a numerator bit, try to subtract.
    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic [W-1:0]       rem_prev;
        logic [63:0]        nq_prev;
        logic [W-1:0]       den_prev;
        bsc_pkg::bsc_side_t side_prev;
        logic [W:0]         trial;
        logic               ge;
        logic [W-1:0]       rem_next;
        logic [63:0]        nq_next;

        if (i == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign nq_prev   = numer;
            assign den_prev  = denom;
            assign side_prev = side_in;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[i-1];
            assign nq_prev   = nq_reg[i-1];
            assign den_prev  = den_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        always_comb
        begin
            trial    = {rem_prev, nq_prev[63]};
            ge       = (trial >= {1'b0, den_prev});
            rem_next = ge ? W'(trial - {1'b0, den_prev}) : trial[W-1:0];
            nq_next  = {nq_prev[62:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next;
                nq_reg[i]   <= nq_next;
                den_reg[i]  <= den_prev;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign quot      = nq_reg[N-1];
    assign side_out  = side_reg[N-1];

    // A stalled pipeline keeps its contents.
    `BSC_ASSERT_NXT(a_stall_holds_valid, !adv, $stable(vld_reg))
    `BSC_ASSERT_NXT(a_stall_holds_quot, !adv && out_valid, $stable(quot))
    // An item entering while the pipe moves occupies the first stage.
    `BSC_ASSERT_NXT(a_entry_lands, adv && in_valid, vld_reg[0])

endmodule

>>> sv/barometric_sensor_compensation.sv
// ============================================================================
// barometric_sensor_compensation
// Integer compensation of raw temperature and pressure conversions.
// ============================================================================
//
// Channel   Direction  Transaction payload
// s_axis    in         tdata: raw_temperature, raw_pressure
// m_axis    out        tdata: temperature_centi, pressure_pa; tuser: divide_fault
// apb       in/out     calibration registers at byte addresses 0, 8, 16, 24
//
// One item enters per cycle while the pipeline is not frozen (10 polynomial stages,
// 64 divider stages with one quotient bit each, 7 correction stages).
// The last stage is the output register; when it holds an untaken result the
// whole pipeline freezes and s_axis_tready drops, so nothing is lost or doubled.
// Reset clears the calibration registers and all stage valid bits.
//
module barometric_sensor_compensation (
    input  logic        clk,
    input  logic        rst_n,
    // raw_temperature [19:0], raw_pressure [39:20]
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // temperature_centi [18:0], pressure_pa [50:19], zero fill [55:51]
    output logic [55:0] m_axis_tdata,
    // divide_fault [0]
    output logic        m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int NF = bsc_pkg::FRONT_STAGES;
    localparam int NB = bsc_pkg::BACK_STAGES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [47:0] temp_cal_reg;
    logic [63:0] press_lo_reg;
    logic [63:0] press_hi_reg;
    logic [15:0] press_last_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes complete in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg   <= '0;
            press_lo_reg   <= '0;
            press_hi_reg   <= '0;
            press_last_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (bsc_pkg::bsc_reg_t'(paddr[4:3]))
                bsc_pkg::REG_TEMP_CAL:   temp_cal_reg   <= pwdata[47:0];
                bsc_pkg::REG_PRESS_LO:   press_lo_reg   <= pwdata;
                bsc_pkg::REG_PRESS_HI:   press_hi_reg   <= pwdata;
                bsc_pkg::REG_PRESS_LAST: press_last_reg <= pwdata[15:0];
                default:                 press_last_reg <= press_last_reg;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        case (bsc_pkg::bsc_reg_t'(paddr[4:3]))
            bsc_pkg::REG_TEMP_CAL:   prdata = {16'd0, temp_cal_reg};
            bsc_pkg::REG_PRESS_LO:   prdata = press_lo_reg;
            bsc_pkg::REG_PRESS_HI:   prdata = press_hi_reg;
            bsc_pkg::REG_PRESS_LAST: prdata = {48'd0, press_last_reg};
            default:                 prdata = '0;
        endcase
    end

    // Calibration coefficients.
    logic        [15:0] t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = temp_cal_reg[15:0];
    assign t2 = $signed(temp_cal_reg[31:16]);
    assign t3 = $signed(temp_cal_reg[47:32]);
    assign p1 = press_lo_reg[15:0];
    assign p2 = $signed(press_lo_reg[31:16]);
    assign p3 = $signed(press_lo_reg[47:32]);
    assign p4 = $signed(press_lo_reg[63:48]);
    assign p5 = $signed(press_hi_reg[15:0]);
    assign p6 = $signed(press_hi_reg[31:16]);
    assign p7 = $signed(press_hi_reg[47:32]);
    assign p8 = $signed(press_hi_reg[63:48]);
    assign p9 = $signed(press_last_reg);

    // ------------------------------------------------------------------
    // Pipeline control: everything advances unless the output is blocked.
    // ------------------------------------------------------------------
    logic          adv;
    logic [NF-1:0] fvld_reg;
    logic [NB-1:0] bvld_reg;
    logic          div_out_valid;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = bvld_reg[NB-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvld_reg <= '0;
            bvld_reg <= '0;
        end
        else if (adv)
        begin
            fvld_reg <= {fvld_reg[NF-2:0], s_axis_tvalid};
            bvld_reg <= {bvld_reg[NB-2:0], div_out_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: first temperature products.
    // ------------------------------------------------------------------
    logic        [19:0] raw_t, raw_p;
    logic signed [17:0] s1_x;
    logic signed [16:0] s1_d;
    logic signed [33:0] s1_xt2_full, s1_dd_full;
    logic        [31:0] s1_xt2_reg, s1_dd_reg;
    logic        [19:0] s1_rawp_reg;

    assign raw_t = s_axis_tdata[19:0];
    assign raw_p = s_axis_tdata[39:20];

    always_comb
    begin
        s1_x        = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, t1, 1'b0});
        s1_d        = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, t1});
        s1_xt2_full = s1_x * t2;
        s1_dd_full  = s1_d * s1_d;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_xt2_reg  <= s1_xt2_full[31:0];
            s1_dd_reg   <= s1_dd_full[31:0];
            s1_rawp_reg <= raw_p;
        end
    end

    // Stage 2: scale and apply T3.
    logic signed [31:0] s2_a_next, s2_ddh;
    logic signed [35:0] s2_b_full;
    logic        [31:0] s2_a_reg, s2_b_reg;
    logic        [19:0] s2_rawp_reg;

    always_comb
    begin
        s2_a_next = $signed(s1_xt2_reg) >>> 11;
        s2_ddh    = $signed(s1_dd_reg) >>> 12;
        s2_b_full = $signed(s2_ddh[19:0]) * t3;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_a_reg    <= s2_a_next;
            s2_b_reg    <= s2_b_full[31:0];
            s2_rawp_reg <= s1_rawp_reg;
        end
    end

    // Stage 3: fine temperature.
    logic signed [31:0] s3_b;
    logic        [31:0] s3_fine_next, s3_fine_reg;
    logic        [19:0] s3_rawp_reg;

    always_comb
    begin
        s3_b         = $signed(s2_b_reg) >>> 14;
        s3_fine_next = s2_a_reg + s3_b;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_fine_reg <= s3_fine_next;
            s3_rawp_reg <= s2_rawp_reg;
        end
    end

    // Stage 4: centidegrees and the pressure offset term.
    logic        [31:0] s4_round;
    logic signed [32:0] s4_v1_next, s4_v1_reg;
    logic        [18:0] s4_centi_reg;
    logic        [19:0] s4_rawp_reg;

    always_comb
    begin
        s4_round   = {s3_fine_reg[29:0], 2'b00} + s3_fine_reg + bsc_pkg::CENTI_ROUND;
        s4_v1_next = $signed({s3_fine_reg[31], s3_fine_reg}) - $signed(bsc_pkg::FINE_OFFSET);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_v1_reg    <= s4_v1_next;
            s4_centi_reg <= s4_round[26:8];
            s4_rawp_reg  <= s3_rawp_reg;
        end
    end

    // Stage 5: square and linear products of the offset term.
    logic signed [65:0] s5_vv_full;
    logic signed [48:0] s5_v1p5_next, s5_v1p2_next;
    logic        [63:0] s5_vv_reg;
    logic signed [48:0] s5_v1p5_reg, s5_v1p2_reg;
    logic        [18:0] s5_centi_reg;
    logic        [19:0] s5_rawp_reg;

    always_comb
    begin
        s5_vv_full   = s4_v1_reg * s4_v1_reg;
        s5_v1p5_next = s4_v1_reg * p5;
        s5_v1p2_next = s4_v1_reg * p2;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_vv_reg    <= s5_vv_full[63:0];
            s5_v1p5_reg  <= s5_v1p5_next;
            s5_v1p2_reg  <= s5_v1p2_next;
            s5_centi_reg <= s4_centi_reg;
            s5_rawp_reg  <= s4_rawp_reg;
        end
    end

    // Stage 6: quadratic coefficients.
    logic signed [79:0] s6_p6_full, s6_p3_full;
    logic        [63:0] s6_vvp6_reg, s6_vvp3_reg;
    logic signed [48:0] s6_v1p5_reg, s6_v1p2_reg;
    logic        [18:0] s6_centi_reg;
    logic        [19:0] s6_rawp_reg;

    always_comb
    begin
        s6_p6_full = $signed(s5_vv_reg) * p6;
        s6_p3_full = $signed(s5_vv_reg) * p3;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_vvp6_reg  <= s6_p6_full[63:0];
            s6_vvp3_reg  <= s6_p3_full[63:0];
            s6_v1p5_reg  <= s5_v1p5_reg;
            s6_v1p2_reg  <= s5_v1p2_reg;
            s6_centi_reg <= s5_centi_reg;
            s6_rawp_reg  <= s5_rawp_reg;
        end
    end

    // Stage 7: sum the numerator offset and the divisor terms.
    logic [63:0] s7_v2_next, s7_v1b_next;
    logic [63:0] s7_v2_reg, s7_v1b_reg;
    logic [18:0] s7_centi_reg;
    logic [19:0] s7_rawp_reg;

    always_comb
    begin
        s7_v2_next  = s6_vvp6_reg
                    + {s6_v1p5_reg[46:0], 17'd0}
                    + {{13{p4[15]}}, p4, 35'd0};
        s7_v1b_next = 64'($signed(s6_vvp3_reg) >>> 8)
                    + {{3{s6_v1p2_reg[48]}}, s6_v1p2_reg, 12'd0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_v2_reg    <= s7_v2_next;
            s7_v1b_reg   <= s7_v1b_next;
            s7_centi_reg <= s6_centi_reg;
            s7_rawp_reg  <= s6_rawp_reg;
        end
    end

    // Stage 8: scale the divisor by P1 and form the numerator base.
    logic [20:0] s8_pbase;
    logic [63:0] s8_bias;
    logic [79:0] s8_m_full;
    logic [63:0] s8_n0_next, s8_m_reg, s8_n0_reg;
    logic [18:0] s8_centi_reg;

    always_comb
    begin
        s8_pbase   = bsc_pkg::PRESS_FULL - {1'b0, s7_rawp_reg};
        s8_bias    = s7_v1b_reg + bsc_pkg::P1_BIAS;
        s8_m_full  = s8_bias * p1;
        s8_n0_next = {12'd0, s8_pbase, 31'd0} - s7_v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_m_reg     <= s8_m_full[63:0];
            s8_n0_reg    <= s8_n0_next;
            s8_centi_reg <= s7_centi_reg;
        end
    end

    // Stage 9: final numerator and divisor.
    logic [75:0]                   s9_num_full;
    logic [63:0]                   s9_num_reg;
    logic [bsc_pkg::DEN_W-1:0]     s9_den_reg;
    logic [18:0]                   s9_centi_reg;

    assign s9_num_full = s8_n0_reg * bsc_pkg::PRESS_SCALE;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_num_reg   <= s9_num_full[63:0];
            s9_den_reg   <= s8_m_reg[63:33];
            s9_centi_reg <= s8_centi_reg;
        end
    end

    // Stage 10: magnitudes and signs for the divider.
    logic [63:0]               s10_an_next, s10_an_reg;
    logic [bsc_pkg::DEN_W-1:0] s10_ad_next, s10_ad_reg;
    bsc_pkg::bsc_side_t        s10_side_next, s10_side_reg;

    always_comb
    begin
        s10_an_next = s9_num_reg[63] ? (64'd0 - s9_num_reg) : s9_num_reg;
        s10_ad_next = s9_den_reg[bsc_pkg::DEN_W-1] ? ('0 - s9_den_reg) : s9_den_reg;
        s10_side_next.temp_centi = s9_centi_reg;
        s10_side_next.fault      = (s9_den_reg == '0);
        s10_side_next.q_neg      = s9_num_reg[63] ^ s9_den_reg[bsc_pkg::DEN_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s10_an_reg   <= s10_an_next;
            s10_ad_reg   <= s10_ad_next;
            s10_side_reg <= s10_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Division
    // ------------------------------------------------------------------
    logic [63:0]        div_quot;
    bsc_pkg::bsc_side_t div_side;

    bsc_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fvld_reg[NF-1]),
        .numer     (s10_an_reg),
        .denom     (s10_ad_reg),
        .side_in   (s10_side_reg),
        .out_valid (div_out_valid),
        .quot      (div_quot),
        .side_out  (div_side)
    );

    // ------------------------------------------------------------------
    // Correction stages after the division.
    // ------------------------------------------------------------------
    bsc_pkg::bsc_side_t bside_reg [NB];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bside_reg[0] <= div_side;
            for (int k = 1; k < NB; k++)
            begin
                bside_reg[k] <= bside_reg[k-1];
            end
        end
    end

    // Back 1: signed quotient.
    logic [63:0] b1_p_next, b1_p_reg;

    assign b1_p_next = div_side.q_neg ? (64'd0 - div_quot) : div_quot;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_p_reg <= b1_p_next;
        end
    end

    // Back 2: partial products of the square, and the P8 term.
    logic        [63:0] b2_ps;
    logic        [63:0] b2_lo_full, b2_cr_full;
    logic signed [79:0] b2_p8_full;
    logic        [63:0] b2_lo_reg, b2_p8_reg, b2_p_reg;
    logic        [31:0] b2_cr_reg;

    always_comb
    begin
        b2_ps      = $signed(b1_p_reg) >>> 13;
        b2_lo_full = b2_ps[31:0] * b2_ps[31:0];
        b2_cr_full = b2_ps[31:0] * b2_ps[63:32];
        b2_p8_full = $signed(b1_p_reg) * p8;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b2_lo_reg <= b2_lo_full;
            b2_cr_reg <= b2_cr_full[31:0];
            b2_p8_reg <= b2_p8_full[63:0];
            b2_p_reg  <= b1_p_reg;
        end
    end

    // Back 3: assemble the wrapped square, shift the P8 term.
    logic [63:0] b3_sq_next, b3_w2_next;
    logic [63:0] b3_sq_reg, b3_w2_reg, b3_p_reg;

    always_comb
    begin
        b3_sq_next = b2_lo_reg + {b2_cr_reg[30:0], 33'd0};
        b3_w2_next = $signed(b2_p8_reg) >>> 19;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b3_sq_reg <= b3_sq_next;
            b3_w2_reg <= b3_w2_next;
            b3_p_reg  <= b2_p_reg;
        end
    end

    // Back 4: P9 term.
    logic signed [79:0] b4_w1_full;
    logic        [63:0] b4_w1p_reg, b4_w2_reg, b4_p_reg;

    assign b4_w1_full = $signed(b3_sq_reg) * p9;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b4_w1p_reg <= b4_w1_full[63:0];
            b4_w2_reg  <= b3_w2_reg;
            b4_p_reg   <= b3_p_reg;
        end
    end

    // Back 5: sum of the corrections.
    logic [63:0] b5_s_next, b5_s_reg;

    assign b5_s_next = b4_p_reg + 64'($signed(b4_w1p_reg) >>> 25) + b4_w2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b5_s_reg <= b5_s_next;
        end
    end

    // Back 6: Q24.8 pressure with the P7 offset.
    logic [63:0] b6_pp_next, b6_pp_reg;

    assign b6_pp_next = 64'($signed(b5_s_reg) >>> 8) + {{44{p7[15]}}, p7, 4'd0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b6_pp_reg <= b6_pp_next;
        end
    end

    // Back 7: divide by 256 toward zero; output register.
    logic [63:0]  b7_bias;
    logic [63:0]  b7_q;
    logic [31:0]  out_press_reg;
    logic [18:0]  out_centi_reg;
    logic         out_fault_reg;

    always_comb
    begin
        b7_bias = b6_pp_reg + (b6_pp_reg[63] ? bsc_pkg::DIV256_BIAS : 64'd0);
        b7_q    = $signed(b7_bias) >>> 8;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_press_reg <= bside_reg[NB-2].fault ? 32'd0 : b7_q[31:0];
            out_centi_reg <= bside_reg[NB-2].temp_centi;
            out_fault_reg <= bside_reg[NB-2].fault;
        end
    end

    assign m_axis_tdata = {5'd0, out_press_reg, out_centi_reg};
    assign m_axis_tuser = out_fault_reg && bside_reg[NB-1].fault;

endmodule
